// ===== rtl/core/cpcp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpcp_pkg
// Shared types, constants and fixed point helpers of the cascade
// position/current PID controller.
// ----------------------------------------------------------------------------
package cpcp_pkg;

	localparam int ADC_W   = 10;
	localparam int DATA_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = 53;
	localparam int MULB_W  = 21;
	localparam int NUM_W   = 36;
	localparam int DIVN_W  = 34;
	localparam int DIVD_W  = 14;

	// calibration polynomial coefficients in Q16.16
	localparam logic signed [DATA_W-1:0] POLY_A0 = 32'sd678099;
	localparam logic signed [DATA_W-1:0] POLY_A1 = -32'sd187415;
	localparam logic signed [DATA_W-1:0] POLY_A2 = 32'sd19353;
	localparam logic signed [DATA_W-1:0] POLY_A3 = -32'sd1040;

	// current sensor offset and gain in Q16.16
	localparam logic signed [DATA_W-1:0] AMP_OFF  = -32'sd163840;
	localparam logic signed [MULB_W-1:0] AMP_GAIN = 21'sd87381;

	localparam logic signed [63:0] INT_LIM = 64'sd3342336;
	localparam logic signed [63:0] OUT_LIM = 64'sd33423360;
	localparam logic signed [63:0] DUTY_OFS = 64'sd33554432;
	localparam logic [ADC_W-1:0] DUTY_MID = 10'd512;

	// divisors: adc full scale, sample rate, twice the sample rate (all doubled)
	localparam logic [DIVD_W-1:0] DEN_ADC  = 14'd2046;
	localparam logic [DIVD_W-1:0] DEN_DER  = 14'd5000;
	localparam logic [DIVD_W-1:0] DEN_INT  = 14'd10000;

	// reciprocals of the odd divisor parts, scaled by 2^41 and rounded up
	localparam logic [31:0] RCP_1023 = 32'd2149582851;
	localparam logic [31:0] RCP_625  = 32'd3518437209;
	localparam int          RCP_SH   = 41;

	// register indexes
	localparam logic [3:0] REG_TARGET = 4'd0;
	localparam logic [3:0] REG_KP_POS = 4'd1;
	localparam logic [3:0] REG_KI_POS = 4'd2;
	localparam logic [3:0] REG_KD_POS = 4'd3;
	localparam logic [3:0] REG_KP_CUR = 4'd4;
	localparam logic [3:0] REG_KI_CUR = 4'd5;
	localparam logic [3:0] REG_SMOOTH = 4'd6;
	localparam logic [3:0] REG_STEP   = 4'd7;

	typedef struct packed {
		logic [15:0] target_position;
		logic [15:0] kp_position;
		logic [15:0] ki_position;
		logic [15:0] kd_position;
		logic [15:0] kp_current;
		logic [15:0] ki_current;
		logic [15:0] smoothing;
		logic        step_mode;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD,
		OP_DIV_VP, OP_TAKE_VP, OP_MUL_POLY, OP_ADD_A2, OP_ADD_A1, OP_ADD_A0,
		OP_DIV_VC, OP_TAKE_VC, OP_MUL_AMP, OP_SET_AMP,
		OP_MUL_FA, OP_SET_FA, OP_MUL_FB, OP_SET_FB,
		OP_MUL_EP, OP_SET_EP, OP_DIV_IP, OP_TAKE_IP, OP_DIV_D, OP_TAKE_D,
		OP_MUL_KI, OP_SET_KI, OP_MUL_KD, OP_SET_KD,
		OP_MUL_KPC, OP_SET_EC, OP_DIV_IC, OP_TAKE_IC, OP_MUL_KIC, OP_SET_PC
	} dp_op_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_DIV_VP, ST_WAIT_VP, ST_MUL_P1, ST_ADD_P1, ST_MUL_P2, ST_ADD_P2,
		ST_MUL_P3, ST_ADD_P3, ST_DIV_VC, ST_WAIT_VC, ST_MUL_AMP, ST_SET_AMP,
		ST_MUL_FA, ST_SET_FA, ST_MUL_FB, ST_SET_FB, ST_MUL_EP, ST_SET_EP,
		ST_DIV_IP, ST_WAIT_IP, ST_DIV_D, ST_WAIT_D, ST_MUL_KI, ST_SET_KI,
		ST_MUL_KD, ST_SET_KD, ST_MUL_KPC, ST_SET_EC, ST_DIV_IC, ST_WAIT_IC,
		ST_MUL_KIC, ST_SET_PC, ST_DONE
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
		logic   busy;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic div_done;
	} ctl_sts_t;

	// saturate to the signed 32-bit range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		if (x < -64'sd2147483648)
			return 32'sh80000000;
		return x[DATA_W-1:0];
	endfunction

	// round half up then drop n fraction bits
	function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
		return (x + 64'sd32768) >>> FRAC_W;
	endfunction

	function automatic logic signed [63:0] rnd8(input logic signed [63:0] x);
		return (x + 64'sd128) >>> 8;
	endfunction

	// clamp an integrator to its limit
	function automatic logic signed [DATA_W-1:0] clamp_int(input logic signed [63:0] x);
		if (x > INT_LIM)
			return INT_LIM[DATA_W-1:0];
		if (x < -INT_LIM)
			return DATA_W'(-INT_LIM);
		return x[DATA_W-1:0];
	endfunction

endpackage

// ===== rtl/core/cpcp_div.sv =====
// ----------------------------------------------------------------------------
// cpcp_div
// Unsigned division by one of the fixed divisors through reciprocal
// multiplication; done marks the registered quotient as ready.
// ----------------------------------------------------------------------------
module cpcp_div import cpcp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVN_W-1:0] num,
	input  logic [DIVD_W-1:0] den,
	output logic [DIVN_W-1:0] quo,
	output logic              done
);

	logic        busy_q;
	logic        done_q;
	logic [31:0] num_q;
	logic [31:0] rcp_q;
	logic [63:0] prod_q;
	logic [31:0] num_sh;
	logic [31:0] rcp;

	// drop the power of two of the divisor, pick the reciprocal of its odd part
	always_comb begin
		num_sh = '0;
		rcp    = '0;
		case (den)
			DEN_ADC: begin
				num_sh = 32'(num >> 1);
				rcp    = RCP_1023;
			end
			DEN_DER: begin
				num_sh = 32'(num >> 3);
				rcp    = RCP_625;
			end
			DEN_INT: begin
				num_sh = 32'(num >> 4);
				rcp    = RCP_625;
			end
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	// operand capture and product
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num_sh;
			rcp_q <= rcp;
		end
		if (busy_q)
			prod_q <= num_q * rcp_q;
	end

	assign quo  = DIVN_W'(prod_q[63:RCP_SH]);
	assign done = done_q;

endmodule

// ===== rtl/core/cpcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpcp_ctrl
// Sequencer of one control tick: steps the shared multiplier and divider.
// ----------------------------------------------------------------------------
module cpcp_ctrl import cpcp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:    if (sts.in_valid) state_nx = ST_DIV_VP;
			ST_DIV_VP:  state_nx = ST_WAIT_VP;
			ST_WAIT_VP: if (sts.div_done) state_nx = ST_MUL_P1;
			ST_MUL_P1:  state_nx = ST_ADD_P1;
			ST_ADD_P1:  state_nx = ST_MUL_P2;
			ST_MUL_P2:  state_nx = ST_ADD_P2;
			ST_ADD_P2:  state_nx = ST_MUL_P3;
			ST_MUL_P3:  state_nx = ST_ADD_P3;
			ST_ADD_P3:  state_nx = ST_DIV_VC;
			ST_DIV_VC:  state_nx = ST_WAIT_VC;
			ST_WAIT_VC: if (sts.div_done) state_nx = ST_MUL_AMP;
			ST_MUL_AMP: state_nx = ST_SET_AMP;
			ST_SET_AMP: state_nx = ST_MUL_FA;
			ST_MUL_FA:  state_nx = ST_SET_FA;
			ST_SET_FA:  state_nx = ST_MUL_FB;
			ST_MUL_FB:  state_nx = ST_SET_FB;
			ST_SET_FB:  state_nx = ST_MUL_EP;
			ST_MUL_EP:  state_nx = ST_SET_EP;
			ST_SET_EP:  state_nx = ST_DIV_IP;
			ST_DIV_IP:  state_nx = ST_WAIT_IP;
			ST_WAIT_IP: if (sts.div_done) state_nx = ST_DIV_D;
			ST_DIV_D:   state_nx = ST_WAIT_D;
			ST_WAIT_D:  if (sts.div_done) state_nx = ST_MUL_KI;
			ST_MUL_KI:  state_nx = ST_SET_KI;
			ST_SET_KI:  state_nx = ST_MUL_KD;
			ST_MUL_KD:  state_nx = ST_SET_KD;
			ST_SET_KD:  state_nx = ST_MUL_KPC;
			ST_MUL_KPC: state_nx = ST_SET_EC;
			ST_SET_EC:  state_nx = ST_DIV_IC;
			ST_DIV_IC:  state_nx = ST_WAIT_IC;
			ST_WAIT_IC: if (sts.div_done) state_nx = ST_MUL_KIC;
			ST_MUL_KIC: state_nx = ST_SET_PC;
			ST_SET_PC:  state_nx = ST_DONE;
			ST_DONE:    if (sts.out_free) state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		cmd.busy     = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE:    if (sts.in_valid) cmd.op = OP_LOAD;
			ST_DIV_VP:  cmd.op = OP_DIV_VP;
			ST_WAIT_VP: if (sts.div_done) cmd.op = OP_TAKE_VP;
			ST_MUL_P1:  cmd.op = OP_MUL_POLY;
			ST_ADD_P1:  cmd.op = OP_ADD_A2;
			ST_MUL_P2:  cmd.op = OP_MUL_POLY;
			ST_ADD_P2:  cmd.op = OP_ADD_A1;
			ST_MUL_P3:  cmd.op = OP_MUL_POLY;
			ST_ADD_P3:  cmd.op = OP_ADD_A0;
			ST_DIV_VC:  cmd.op = OP_DIV_VC;
			ST_WAIT_VC: if (sts.div_done) cmd.op = OP_TAKE_VC;
			ST_MUL_AMP: cmd.op = OP_MUL_AMP;
			ST_SET_AMP: cmd.op = OP_SET_AMP;
			ST_MUL_FA:  cmd.op = OP_MUL_FA;
			ST_SET_FA:  cmd.op = OP_SET_FA;
			ST_MUL_FB:  cmd.op = OP_MUL_FB;
			ST_SET_FB:  cmd.op = OP_SET_FB;
			ST_MUL_EP:  cmd.op = OP_MUL_EP;
			ST_SET_EP:  cmd.op = OP_SET_EP;
			ST_DIV_IP:  cmd.op = OP_DIV_IP;
			ST_WAIT_IP: if (sts.div_done) cmd.op = OP_TAKE_IP;
			ST_DIV_D:   cmd.op = OP_DIV_D;
			ST_WAIT_D:  if (sts.div_done) cmd.op = OP_TAKE_D;
			ST_MUL_KI:  cmd.op = OP_MUL_KI;
			ST_SET_KI:  cmd.op = OP_SET_KI;
			ST_MUL_KD:  cmd.op = OP_MUL_KD;
			ST_SET_KD:  cmd.op = OP_SET_KD;
			ST_MUL_KPC: cmd.op = OP_MUL_KPC;
			ST_SET_EC:  cmd.op = OP_SET_EC;
			ST_DIV_IC:  cmd.op = OP_DIV_IC;
			ST_WAIT_IC: if (sts.div_done) cmd.op = OP_TAKE_IC;
			ST_MUL_KIC: cmd.op = OP_MUL_KIC;
			ST_SET_PC:  cmd.op = OP_SET_PC;
			ST_DONE:    cmd.out_load = sts.out_free;
			default:    cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== rtl/core/cpcp_dp.sv =====
// ----------------------------------------------------------------------------
// cpcp_dp
// Datapath: one shared multiplier, one constant divider and the loop state.
// ----------------------------------------------------------------------------
module cpcp_dp import cpcp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_op_t                   op,
	input  cfg_t                     cfg,
	input  logic [ADC_W-1:0]         pose_sample,
	input  logic [ADC_W-1:0]         current_sample,
	output logic                     div_done,
	output logic [ADC_W-1:0]         duty,
	output logic signed [DATA_W-1:0] pid_pos,
	output logic signed [DATA_W-1:0] filt,
	output logic signed [DATA_W-1:0] err
);

	logic [ADC_W-1:0]         pose_q;
	logic [ADC_W-1:0]         curs_q;
	logic signed [MULB_W-1:0] v_q;
	logic signed [DATA_W-1:0] mm_q, amps_q, e_q, d_q, pid_q, ec_q;
	logic signed [DATA_W-1:0] filt_q, pint_q, pprev_q, cint_q, cprev_q;
	logic signed [63:0]       acc_q;
	logic [ADC_W-1:0]         duty_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     neg_q;

	logic signed [DATA_W-1:0] mul_a;
	logic signed [MULB_W-1:0] mul_b;
	logic signed [63:0]       prod;
	logic signed [NUM_W-1:0]  num_s;
	logic [DIVD_W-1:0]        den;
	logic                     div_start;
	logic [NUM_W-1:0]         mag;
	logic [DIVN_W-1:0]        quo;
	logic signed [NUM_W-1:0]  quo_s;
	logic signed [63:0]       pc;
	logic signed [63:0]       pcl;
	logic signed [63:0]       duty_w;

	assign prod = 64'(prod_q);

	// shared multiplier operand select
	always_comb begin
		mul_a = mm_q;
		mul_b = v_q;
		case (op)
			OP_MUL_AMP: begin
				mul_a = DATA_W'(v_q) + AMP_OFF;
				mul_b = AMP_GAIN;
			end
			OP_MUL_FA: begin
				mul_a = filt_q;
				mul_b = $signed(MULB_W'(cfg.smoothing));
			end
			OP_MUL_FB: begin
				mul_a = mm_q;
				mul_b = $signed(MULB_W'(17'h10000 - 17'(cfg.smoothing)));
			end
			OP_MUL_EP: begin
				mul_a = sat32(64'($signed({8'b0, cfg.target_position, 8'b0})) - 64'(filt_q));
				mul_b = $signed(MULB_W'(cfg.kp_position));
			end
			OP_MUL_KI: begin
				mul_a = pint_q;
				mul_b = $signed(MULB_W'(cfg.ki_position));
			end
			OP_MUL_KD: begin
				mul_a = d_q;
				mul_b = $signed(MULB_W'(cfg.kd_position));
			end
			OP_MUL_KPC: begin
				mul_a = sat32(64'(pid_q) - 64'(amps_q));
				mul_b = $signed(MULB_W'(cfg.kp_current));
			end
			OP_MUL_KIC: begin
				mul_a = cint_q;
				mul_b = $signed(MULB_W'(cfg.ki_current));
			end
			default: begin
				mul_a = mm_q;
				mul_b = v_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// divider numerator select, doubled for round half up
	always_comb begin
		div_start = 1'b1;
		num_s     = '0;
		den       = DEN_ADC;
		case (op)
			OP_DIV_VP: num_s = $signed(NUM_W'({pose_q, 16'b0}) * NUM_W'(10) + NUM_W'(1023));
			OP_DIV_VC: num_s = $signed(NUM_W'({curs_q, 16'b0}) * NUM_W'(10) + NUM_W'(1023));
			OP_DIV_IP: begin
				num_s = ((NUM_W'(e_q) + NUM_W'(pprev_q)) <<< 1) + NUM_W'(5000);
				den   = DEN_INT;
			end
			OP_DIV_D: begin
				num_s = ((NUM_W'(e_q) - NUM_W'(pprev_q)) <<< 1) + NUM_W'(2500);
				den   = DEN_DER;
			end
			OP_DIV_IC: begin
				num_s = ((NUM_W'(ec_q) + NUM_W'(cprev_q)) <<< 1) + NUM_W'(5000);
				den   = DEN_INT;
			end
			default: div_start = 1'b0;
		endcase
		// floor division of a negative numerator through its magnitude
		if (num_s < 0)
			mag = NUM_W'(-num_s) + NUM_W'(den) - NUM_W'(1);
		else
			mag = num_s;
	end

	cpcp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag[DIVN_W-1:0]),
		.den    (den),
		.quo    (quo),
		.done   (div_done)
	);

	always_ff @(posedge clk) begin
		if (div_start)
			neg_q <= num_s < 0;
	end

	assign quo_s = neg_q ? -$signed(NUM_W'(quo)) : $signed(NUM_W'(quo));

	// inner loop output and duty
	always_comb begin
		pc = 64'(ec_q) + rnd8(prod);
		if (pc > OUT_LIM)
			pcl = OUT_LIM;
		else if (pc < -OUT_LIM)
			pcl = -OUT_LIM;
		else
			pcl = pc;
		duty_w = pcl + DUTY_OFS;
	end

	// working registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				pose_q <= pose_sample;
				curs_q <= current_sample;
				mm_q   <= POLY_A3;
			end
			OP_TAKE_VP, OP_TAKE_VC: v_q <= quo_s[MULB_W-1:0];
			OP_ADD_A2:  mm_q   <= DATA_W'(rnd16(prod) + 64'(POLY_A2));
			OP_ADD_A1:  mm_q   <= DATA_W'(rnd16(prod) + 64'(POLY_A1));
			OP_ADD_A0:  mm_q   <= sat32(rnd16(prod) + 64'(POLY_A0));
			OP_SET_AMP: amps_q <= sat32(rnd16(prod));
			OP_SET_FA:  acc_q  <= prod;
			OP_SET_EP:  e_q    <= sat32(rnd8(prod));
			OP_TAKE_D:  d_q    <= DATA_W'(quo_s);
			OP_SET_KI:  acc_q  <= 64'(e_q) + rnd8(prod);
			OP_SET_KD:  pid_q  <= sat32(acc_q + rnd8(prod));
			OP_SET_EC:  ec_q   <= sat32(rnd8(prod));
			OP_SET_PC:  duty_q <= cfg.step_mode ? DUTY_MID : duty_w[25:16];
			default: ;
		endcase
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q  <= '0;
			pint_q  <= '0;
			pprev_q <= '0;
			cint_q  <= '0;
			cprev_q <= '0;
		end else begin
			case (op)
				OP_SET_FB:  filt_q  <= sat32(rnd16(acc_q + prod));
				OP_TAKE_IP: pint_q  <= clamp_int(64'(pint_q) + 64'(quo_s));
				OP_SET_KD:  pprev_q <= e_q;
				OP_TAKE_IC: cint_q  <= clamp_int(64'(cint_q) + 64'(quo_s));
				OP_SET_PC:  cprev_q <= ec_q;
				default: ;
			endcase
		end
	end

	assign duty    = duty_q;
	assign pid_pos = pid_q;
	assign filt    = filt_q;
	assign err     = e_q;

endmodule

// ===== rtl/core/cascade_position_current_pid_top.sv =====
// ----------------------------------------------------------------------------
// cascade_position_current_pid_top
// Cascade position/current PID controller, one control tick per item.
//
//   channel   signals                                   direction
//   in        in_valid, in_stall, pose_sample,
//             current_sample                            to block
//   out       out_valid, out_stall, pwm_duty,
//             current_command, position_filtered,
//             position_error                            from block
//   cfg       cfg_write, cfg_index, cfg_data            to block
//
// Each item runs an accept, five constant divisions and eleven multiplier
// steps, each a multiply and then a store, and a load of the output
// register; the result is valid once it is loaded there.
// The next item is taken while a finished result waits in the output register.
// Reset clears the loop state and loads the register defaults.
// A stalled output holds its item; the block then waits before its last step.
// ----------------------------------------------------------------------------
module cascade_position_current_pid_top import cpcp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [ADC_W-1:0]         pose_sample,
	input  logic [ADC_W-1:0]         current_sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ADC_W-1:0]         pwm_duty,
	output logic signed [DATA_W-1:0] current_command,
	output logic signed [DATA_W-1:0] position_filtered,
	output logic signed [DATA_W-1:0] position_error,
	input  logic                     cfg_write,
	input  logic [3:0]               cfg_index,
	input  logic [15:0]              cfg_data
);

	cfg_t     cfg_q;
	ctl_cmd_t cmd;
	ctl_sts_t sts;
	logic     out_valid_q;
	logic     div_done;
	logic [ADC_W-1:0]         duty;
	logic signed [DATA_W-1:0] pid_pos, filt, err;
	logic [ADC_W-1:0]         duty_q;
	logic signed [DATA_W-1:0] pid_q, filt_q, err_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_position <= 16'd1372;
			cfg_q.kp_position     <= 16'd384;
			cfg_q.ki_position     <= 16'd2560;
			cfg_q.kd_position     <= 16'd3840;
			cfg_q.kp_current      <= 16'd1024;
			cfg_q.ki_current      <= 16'd2048;
			cfg_q.smoothing       <= 16'd58982;
			cfg_q.step_mode       <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_TARGET: cfg_q.target_position <= cfg_data;
				REG_KP_POS: cfg_q.kp_position     <= cfg_data;
				REG_KI_POS: cfg_q.ki_position     <= cfg_data;
				REG_KD_POS: cfg_q.kd_position     <= cfg_data;
				REG_KP_CUR: cfg_q.kp_current      <= cfg_data;
				REG_KI_CUR: cfg_q.ki_current      <= cfg_data;
				REG_SMOOTH: cfg_q.smoothing       <= cfg_data;
				REG_STEP:   cfg_q.step_mode       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// controller status
	always_comb begin
		sts.in_valid = in_valid;
		sts.out_free = !out_valid_q || !out_stall;
		sts.div_done = div_done;
	end

	cpcp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	cpcp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (cmd.op),
		.cfg            (cfg_q),
		.pose_sample    (pose_sample),
		.current_sample (current_sample),
		.div_done       (div_done),
		.duty           (duty),
		.pid_pos        (pid_pos),
		.filt           (filt),
		.err            (err)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			duty_q <= duty;
			pid_q  <= pid_pos;
			filt_q <= filt;
			err_q  <= err;
		end
	end

	assign in_stall          = cmd.busy;
	assign out_valid         = out_valid_q;
	assign pwm_duty          = duty_q;
	assign current_command   = pid_q;
	assign position_filtered = filt_q;
	assign position_error    = err_q;

endmodule
